// ----- hw/rtl/pli_pkg.sv -----
// shared constants and types for the positional list block
// no dependencies; imported by the sequencer and the top level of the block
package pli_pkg;

  // list geometry
  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // field widths
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // port request toward the entry memory
  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
  } ram_req_t;

endpackage

// ----- hw/rtl/pli_ram.sv -----
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/pli_seq.sv -----
// request sequencer: decodes a request, walks the entry memory for shifts,
// keeps the entry count and holds the result word; uses pli_pkg
module pli_seq
  import pli_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [ADDR_W-1:0]    in_position,
  input  logic [WORD_BITS-1:0] in_entry_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] out_read_data,
  output logic [STAT_W-1:0]    out_status,
  output logic [CNT_W-1:0]     out_entry_count,
  output logic                 out_is_full,
  output logic                 out_is_empty,
  output ram_req_t             ram_req,
  input  logic [WORD_BITS-1:0] ram_rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_RESULT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]    cur_r, cur_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic [WORD_BITS-1:0] res_data_r, res_data_nxt;
  logic [STAT_W-1:0]    res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  logic              occupied;
  logic              full;
  logic [ADDR_W-1:0] last_idx;

  assign occupied = {1'b0, in_position} < count_r;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign last_idx = ADDR_W'(count_r - CNT_W'(1));

  assign in_ready = (state_r == S_IDLE);

  // next state, memory accesses and result capture
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt        = in_position;
          val_nxt        = in_entry_value;
          res_data_nxt   = '0;
          res_status_nxt = ST_DONE;
          state_nxt      = S_RESULT;
          unique case (in_req_type)
            REQ_READ: begin
              if (occupied) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = in_position;
                state_nxt       = S_RD_WAIT;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            REQ_WRITE: begin
              if (occupied) begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = in_position;
                ram_req.wr_data = in_entry_value;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            REQ_APPEND: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = ADDR_W'(count_r);
                ram_req.wr_data = in_entry_value;
                count_nxt       = count_r + CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else if (!occupied) begin
                res_status_nxt = ST_RANGE;
              end else begin
                // start moving entries up from the tail
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = last_idx;
                cur_nxt         = last_idx;
                state_nxt       = S_SHIFT_UP;
              end
            end
            REQ_REMOVE: begin
              if (!occupied) begin
                res_status_nxt = ST_RANGE;
              end else if (in_position == last_idx) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                // start moving entries down from just past the hole
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = in_position + ADDR_W'(1);
                cur_nxt         = in_position + ADDR_W'(1);
                state_nxt       = S_SHIFT_DN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        res_data_nxt = ram_rd_data;
        state_nxt    = S_RESULT;
      end

      // entry cur arrives, goes to cur+1; next read one lower
      S_SHIFT_UP: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = cur_r + ADDR_W'(1);
        ram_req.wr_data = ram_rd_data;
        if (cur_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = cur_r - ADDR_W'(1);
          cur_nxt         = cur_r - ADDR_W'(1);
        end
      end

      S_PUT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = pos_r;
        ram_req.wr_data = val_r;
        count_nxt       = count_r + CNT_W'(1);
        state_nxt       = S_RESULT;
      end

      // entry cur arrives, goes to cur-1; next read one higher
      S_SHIFT_DN: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = cur_r - ADDR_W'(1);
        ram_req.wr_data = ram_rd_data;
        if (cur_r == last_idx) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESULT;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = cur_r + ADDR_W'(1);
          cur_nxt         = cur_r + ADDR_W'(1);
        end
      end

      // hand the result word to the output register once it is free
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, count and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_is_full     = (out_count_r == CNT_W'(DEPTH));
  assign out_is_empty    = (out_count_r == '0);

endmodule

// ----- hw/rtl/positional_list_insert_remove.sv -----
// top level of the positional list: stream ports, word packing,
// entry memory and request sequencer; uses pli_pkg, pli_ram and pli_seq
//
// An ordered list of up to 64 words of 32 bits held in one simple dual-port
// memory. Each input word carries one request (read, overwrite, append,
// insert at position, remove at position) and yields exactly one result word
// with the read data, a status and the entry count with full and empty flags.
// One request is handled at a time. A read waits for the registered memory
// read; an insert at position p moves entries p to n - 1 of a list of n
// entries up by one and a remove moves entries p + 1 to n - 1 down by one,
// and the memory's single write port moves one entry per cycle during a
// shift. The result sits in an output register, so the next request can be
// accepted while the previous result waits.
module positional_list_insert_remove
  import pli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], entry_value[37:6], zero pad
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_data[31:0], status[33:32],
                                  // entry_count[40:34], is_full[41],
                                  // is_empty[42], zero pad
);

  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rd_data;
  logic [WORD_BITS-1:0] read_data;
  logic [STAT_W-1:0]    status;
  logic [CNT_W-1:0]     entry_count;
  logic                 is_full;
  logic                 is_empty;

  // entry memory
  pli_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  // request sequencer
  pli_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_req_type     (in_tuser),
    .in_position     (in_tdata[5:0]),
    .in_entry_value  (in_tdata[37:6]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_read_data   (read_data),
    .out_status      (status),
    .out_entry_count (entry_count),
    .out_is_full     (is_full),
    .out_is_empty    (is_empty),
    .ram_req         (ram_req),
    .ram_rd_data     (ram_rd_data)
  );

  // result word packing
  assign out_tdata = {5'b0, is_empty, is_full, entry_count, status, read_data};

endmodule

// ----- dv/positional_list_insert_remove_tb.sv -----
// self-checking testbench for the positional list: a directed table, then random requests
// checked against a predictor of the list held here; needs pli_pkg and the top level
module positional_list_insert_remove_tb
  import pli_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // request codes the block leaves unused
  localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam int RAND_REQS    = 900;
  localparam int PHASE_REQS   = 120;
  localparam int LIMIT_CYCLES = 500000;
  localparam int N_ROWS       = 24;

  // one result word, packed as on out_tdata
  typedef struct packed {
    logic                 is_empty;
    logic                 is_full;
    logic [CNT_W-1:0]     count;
    logic [STAT_W-1:0]    status;
    logic [WORD_BITS-1:0] read_data;
  } list_result_t;

  // directed row; the expected fields apply only where typed is set
  typedef struct {
    logic [REQ_W-1:0]     req;
    logic [ADDR_W-1:0]    pos;
    logic [WORD_BITS-1:0] val;
    bit                   typed;
    logic [WORD_BITS-1:0] exp_rd;
    logic [STAT_W-1:0]    exp_st;
    logic [CNT_W-1:0]     exp_cnt;
  } dir_row_t;

  typedef enum int {GROW, SHRINK, MIXED} phase_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // position[5:0], entry_value[37:6], zero pad
  logic [2:0]  in_tuser = '0;    // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // read_data[31:0], status[33:32], entry_count[40:34],
                                 // is_full[41], is_empty[42], zero pad

  // predicted list contents and pending results
  logic [WORD_BITS-1:0] list_words [DEPTH];
  int                   list_len;
  list_result_t         pending_results [$];

  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  bit  steady = 1'b0;

  dir_row_t dir_rows [N_ROWS] = '{
    '{REQ_READ,    6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
    '{REQ_WRITE,   6'd0,  32'h1111_1111, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
    '{REQ_INSERT,  6'd0,  32'h2222_2222, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
    '{REQ_REMOVE,  6'd63, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
    '{REQ_SPARE_5, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  7'd0},
    '{REQ_APPEND,  6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  7'd1},
    '{REQ_APPEND,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd2},
    '{REQ_READ,    6'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_DONE,  7'd2},
    '{REQ_READ,    6'd1,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  7'd2},
    '{REQ_READ,    6'd2,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd2},
    '{REQ_READ,    6'd63, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd2},
    '{REQ_INSERT,  6'd0,  32'h1234_5678, 1'b0, '0, '0, '0},
    '{REQ_INSERT,  6'd2,  32'hA5A5_A5A5, 1'b0, '0, '0, '0},
    '{REQ_WRITE,   6'd3,  32'hDEAD_BEEF, 1'b0, '0, '0, '0},
    '{REQ_WRITE,   6'd0,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_SPARE_6, 6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd4},
    '{REQ_SPARE_7, 6'd21, 32'h5A5A_5A5A, 1'b0, '0, '0, '0},
    '{REQ_REMOVE,  6'd3,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_REMOVE,  6'd0,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_READ,    6'd0,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_READ,    6'd1,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_REMOVE,  6'd1,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_REMOVE,  6'd0,  32'h0000_0000, 1'b0, '0, '0, '0},
    '{REQ_REMOVE,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0}
  };

  positional_list_insert_remove i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // flags follow the count
  function automatic list_result_t flags_for(input logic [WORD_BITS-1:0] rd,
                                             input logic [STAT_W-1:0] st,
                                             input int cnt);
    list_result_t res;
    res.read_data = rd;
    res.status    = st;
    res.count     = cnt[CNT_W-1:0];
    res.is_full   = (cnt == DEPTH);
    res.is_empty  = (cnt == 0);
    return res;
  endfunction

  // apply one request to the predicted list and give its result
  function automatic list_result_t list_apply(input logic [REQ_W-1:0] req,
                                              input logic [ADDR_W-1:0] pos,
                                              input logic [WORD_BITS-1:0] val);
    logic [WORD_BITS-1:0] rd;
    logic [STAT_W-1:0]    st;
    bit                   hit;
    bit                   full_now;
    rd       = '0;
    st       = ST_DONE;
    hit      = (int'(pos) < list_len);
    full_now = (list_len >= DEPTH);
    case (req)
      REQ_READ: begin
        if (hit) rd = list_words[pos];
        else st = ST_RANGE;
      end
      REQ_WRITE: begin
        if (hit) list_words[pos] = val;
        else st = ST_RANGE;
      end
      REQ_APPEND: begin
        if (full_now) begin
          st = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      REQ_INSERT: begin
        if (full_now) begin
          st = ST_FULL;
        end else if (!hit) begin
          st = ST_RANGE;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        if (!hit) begin
          st = ST_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    return flags_for(rd, st, list_len);
  endfunction

  // present one request word, wait for acceptance, queue what it should return
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] pos,
                          input logic [WORD_BITS-1:0] val, input bit typed,
                          input list_result_t typed_res);
    list_result_t res;
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {2'b00, val, pos};
    do @(posedge clk); while (!in_tready);
    res = list_apply(req, pos, val);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready = steady ? 1'b1 : ($urandom_range(99) >= 36);
  end

  // result checker
  always @(posedge clk) begin : check_results
    list_result_t got_res;
    list_result_t want_res;
    if (rst_n && out_tvalid && out_tready) begin
      got_res = list_result_t'(out_tdata[42:0]);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word: rd=%h st=%0d cnt=%0d full=%b empty=%b",
                   got_res.read_data, got_res.status, got_res.count,
                   got_res.is_full, got_res.is_empty);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.read_data !== want_res.read_data || got_res.status !== want_res.status ||
            got_res.count !== want_res.count || got_res.is_full !== want_res.is_full ||
            got_res.is_empty !== want_res.is_empty) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"result mismatch: exp rd=%h st=%0d cnt=%0d full=%b empty=%b",
                      " | got rd=%h st=%0d cnt=%0d full=%b empty=%b"},
                     want_res.read_data, want_res.status, want_res.count,
                     want_res.is_full, want_res.is_empty,
                     got_res.read_data, got_res.status, got_res.count,
                     got_res.is_full, got_res.is_empty);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // main sequence
  initial begin : stimulus
    int                   sent;
    int                   pick;
    phase_mode_t          mode;
    logic [REQ_W-1:0]     req;
    logic [ADDR_W-1:0]    pos;
    logic [WORD_BITS-1:0] val;
    list_len = 0;
    sent     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed,
               flags_for(dir_rows[i].exp_rd, dir_rows[i].exp_st, int'(dir_rows[i].exp_cnt)));
    end
    drain_results();

    // random phases: fill, drain, mix; the fourth phase runs with no idling
    while (sent < RAND_REQS) begin
      case ((sent / PHASE_REQS) % 3)
        0:       mode = GROW;
        1:       mode = SHRINK;
        default: mode = MIXED;
      endcase
      steady = ((sent / PHASE_REQS) == 3);
      pick = $urandom_range(99);
      case (mode)
        GROW:    req = (pick < 50) ? REQ_APPEND : (pick < 75) ? REQ_INSERT :
                       (pick < 85) ? REQ_READ : (pick < 92) ? REQ_WRITE : REQ_REMOVE;
        SHRINK:  req = (pick < 50) ? REQ_REMOVE : (pick < 65) ? REQ_READ :
                       (pick < 75) ? REQ_WRITE : (pick < 85) ? REQ_APPEND : REQ_INSERT;
        default: req = (pick < 20) ? REQ_READ : (pick < 40) ? REQ_WRITE :
                       (pick < 60) ? REQ_APPEND : (pick < 80) ? REQ_INSERT : REQ_REMOVE;
      endcase
      // an occasional unused code; it does not count toward the total
      if ($urandom_range(99) < 2) req = REQ_W'($urandom_range(5, 7));
      if (list_len > 0 && $urandom_range(99) < 85)
        pos = ADDR_W'($urandom_range(list_len - 1));
      else
        pos = ADDR_W'($urandom_range(DEPTH - 1));
      pick = $urandom_range(9);
      val = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      send_req(req, pos, val, 1'b0, '0);
      if (req <= REQ_REMOVE) begin
        sent++;
        if (sent % PHASE_REQS == 0) drain_results();
      end
    end
    steady = 1'b0;

    // let the last results come back
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
